/* hdl/vpa_pkg.sv */
`default_nettype none
package vpa_pkg;
    localparam int MaxParts = 16;
    localparam int IdxW = $clog2(MaxParts);
    localparam int CntW = $clog2(MaxParts + 1);
    localparam logic [15:0] MemReset = 16'd3000;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0, CMD_FIRST = 3'd1, CMD_BEST = 3'd2,
        CMD_WORST = 3'd3, CMD_FREE = 3'd4, CMD_RESERVE = 3'd5,
        CMD_BAD6 = 3'd6, CMD_BAD7 = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NOFIT = 3'd1, ST_NOID = 3'd2,
        ST_FULL = 3'd3, ST_BAD = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_FREE = 2'd0, KIND_OWNED = 2'd1, KIND_RESV = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_WRITE, S_MERGE, S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic decide;
        logic shift_step;
        logic write;
        logic merge_step;
        logic clear;
    } ctl_t;

    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic merge_done;
        logic need_shift;
        logic need_merge;
    } sts_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] task_id;
        logic [15:0] req_size;
        logic [15:0] req_start;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] block_start;
        logic [15:0] block_size;
    } rsp_t;
endpackage
`default_nettype wire

/* hdl/vpa_if.sv */
`default_nettype none
interface vpa_req_if;
    logic valid;
    logic ready;
    vpa_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vpa_rsp_if;
    logic valid;
    logic ready;
    vpa_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/vpa_ctrl.sv */
`default_nettype none
module vpa_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire vpa_pkg::sts_t sts,
    output vpa_pkg::ctl_t    ctl
);
    import vpa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // status from the decide cycle is only valid once it has been registered,
    // so the shift state checks need_shift itself
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_SCAN;
            S_SCAN:   if (sts.scan_done) state_next = S_DECIDE;
            S_DECIDE: state_next = S_SHIFT;
            S_SHIFT:  if (!sts.need_shift || sts.shift_done) state_next = S_WRITE;
            S_WRITE:  state_next = sts.need_merge ? S_MERGE : S_DONE;
            S_MERGE:  if (sts.merge_done) state_next = S_DONE;
            S_DONE:   if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            S_SCAN:   ctl.scan_step = 1'b1;
            S_DECIDE: ctl.decide = 1'b1;
            S_SHIFT:  ctl.shift_step = 1'b1;
            S_WRITE:  ctl.write = 1'b1;
            S_MERGE:  ctl.merge_step = 1'b1;
            S_DONE:   out_valid = 1'b1;
            default:  ctl = '0;
        endcase
    end
endmodule
`default_nettype wire

/* hdl/vpa_datapath.sv */
`default_nettype none
module vpa_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [15:0]   cfg_data,
    input  wire vpa_pkg::req_t req,
    input  wire vpa_pkg::ctl_t ctl,
    output vpa_pkg::sts_t      sts,
    output vpa_pkg::rsp_t      rsp
);
    import vpa_pkg::*;

    logic [15:0] mem_size_reg;
    logic [15:0] start_reg [MaxParts];
    logic [15:0] size_reg  [MaxParts];
    logic [1:0]  kind_reg  [MaxParts];
    logic [15:0] owner_reg [MaxParts];
    logic [CntW-1:0] count_reg;

    req_t        req_reg;
    logic [CntW-1:0] ptr_reg;     // scan / shift / merge pointer
    logic        found_reg;
    logic [IdxW-1:0] pick_reg;
    logic [15:0] psize_reg;
    logic [15:0] pstart_reg;
    logic [2:0]  status_reg;
    logic [15:0] bst_reg, bsz_reg;
    logic [1:0]  extra_reg;       // new slots needed
    logic        before_reg;
    logic [15:0] bef_reg, aft_reg;
    logic [1:0]  mstep_reg;       // merge phase: 0 next, 1 prev

    logic is_alloc, is_free, is_resv;
    logic [IdxW-1:0] pi;
    logic [15:0] e_st, e_sz;
    logic [1:0]  e_k;
    logic [15:0] e_ow;
    logic [16:0] e_end, r_end;
    logic hit;

    assign is_alloc = req_reg.command == CMD_FIRST || req_reg.command == CMD_BEST
                   || req_reg.command == CMD_WORST;
    assign is_free = req_reg.command == CMD_FREE;
    assign is_resv = req_reg.command == CMD_RESERVE;
    assign pi = ptr_reg[IdxW-1:0];
    assign e_st = start_reg[pi];
    assign e_sz = size_reg[pi];
    assign e_k = kind_reg[pi];
    assign e_ow = owner_reg[pi];
    assign e_end = {1'b0, e_st} + {1'b0, e_sz};
    assign r_end = {1'b0, req_reg.req_start} + {1'b0, req_reg.req_size};

    always_comb
    begin
        hit = 1'b0;
        if (is_alloc)
            hit = e_k == KIND_FREE && e_sz >= req_reg.req_size
               && (!found_reg
                   || (req_reg.command == CMD_BEST && e_sz < psize_reg)
                   || (req_reg.command == CMD_WORST && e_sz > psize_reg));
        else if (is_free)
            hit = !found_reg && e_k == KIND_OWNED && e_ow == req_reg.task_id;
        else if (is_resv)
            hit = !found_reg && e_k == KIND_FREE && e_st <= req_reg.req_start
               && e_end >= r_end;
    end

    logic scan_end;
    assign scan_end = ptr_reg >= count_reg
                   || (found_reg && !(req_reg.command == CMD_BEST
                                      || req_reg.command == CMD_WORST));
    assign sts.scan_done = ctl.scan_step && scan_end;
    assign sts.need_shift = extra_reg != 2'd0 && status_reg == ST_OK;
    assign sts.shift_done = ctl.shift_step && ptr_reg <= {1'b0, pick_reg} + 1'b1;
    assign sts.need_merge = is_free && status_reg == ST_OK;
    assign sts.merge_done = ctl.merge_step && mstep_reg == 2'd2;

    assign rsp.status = status_reg;
    assign rsp.block_start = (status_reg == ST_OK) ? bst_reg : 16'd0;
    assign rsp.block_size = (status_reg == ST_OK) ? bsz_reg : 16'd0;

    // merge helpers
    logic [IdxW-1:0] mi, mn;
    logic dropping_reg;
    assign mi = pick_reg;
    assign mn = pick_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_reg <= MemReset;
            count_reg <= CntW'(1);
            for (int i = 0; i < MaxParts; i++)
            begin
                kind_reg[i] <= KIND_FREE;
                start_reg[i] <= 16'd0;
                size_reg[i] <= 16'd0;
            end
            size_reg[0] <= MemReset;
            ptr_reg <= '0;
            found_reg <= 1'b0;
            status_reg <= ST_OK;
            extra_reg <= '0;
            mstep_reg <= '0;
            dropping_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mem_size_reg <= cfg_data;
            if (ctl.load)
            begin
                req_reg <= req;
                ptr_reg <= '0;
                found_reg <= 1'b0;
                extra_reg <= '0;
                mstep_reg <= '0;
                dropping_reg <= 1'b0;
                status_reg <= ST_BAD;
                bst_reg <= '0;
                bsz_reg <= '0;
            end
            if (ctl.scan_step && !scan_end)
            begin
                if (hit)
                begin
                    found_reg <= 1'b1;
                    pick_reg <= pi;
                    psize_reg <= e_sz;
                    pstart_reg <= e_st;
                end
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (ctl.decide)
            begin
                ptr_reg <= count_reg;
                bst_reg <= pstart_reg;
                bsz_reg <= req_reg.req_size;
                before_reg <= 1'b0;
                case (req_reg.command)
                    CMD_CLEAR:
                    begin
                        status_reg <= ST_OK;
                        bst_reg <= '0;
                        bsz_reg <= mem_size_reg;
                    end
                    CMD_FIRST, CMD_BEST, CMD_WORST:
                    begin
                        if (req_reg.req_size == 16'd0)
                            status_reg <= ST_BAD;
                        else if (!found_reg)
                            status_reg <= ST_NOFIT;
                        else if (psize_reg == req_reg.req_size)
                            status_reg <= ST_OK;
                        else if (count_reg >= CntW'(MaxParts))
                            status_reg <= ST_FULL;
                        else
                        begin
                            status_reg <= ST_OK;
                            extra_reg <= 2'd1;
                            aft_reg <= psize_reg - req_reg.req_size;
                        end
                    end
                    CMD_FREE:
                    begin
                        status_reg <= found_reg ? ST_OK : ST_NOID;
                        bsz_reg <= psize_reg;
                    end
                    CMD_RESERVE:
                    begin
                        bst_reg <= req_reg.req_start;
                        bef_reg <= req_reg.req_start - pstart_reg;
                        aft_reg <= 16'(({1'b0, pstart_reg} + {1'b0, psize_reg}) - r_end);
                        before_reg <= req_reg.req_start != pstart_reg;
                        if (req_reg.req_size == 16'd0)
                            status_reg <= ST_BAD;
                        else if (!found_reg || r_end > 17'h10000)
                            status_reg <= ST_NOFIT;
                        else if ({1'b0, count_reg}
                                 + CntW'(req_reg.req_start != pstart_reg)
                                 + CntW'(r_end != {1'b0, pstart_reg} + {1'b0, psize_reg})
                                 > (CntW+1)'(MaxParts))
                            status_reg <= ST_FULL;
                        else
                        begin
                            status_reg <= ST_OK;
                            extra_reg <= 2'(req_reg.req_start != pstart_reg)
                                + 2'(r_end != {1'b0, pstart_reg} + {1'b0, psize_reg});
                        end
                    end
                    default: status_reg <= ST_BAD;
                endcase
            end
            // move entries up by extra, one per cycle, from the top down
            if (ctl.shift_step && sts.need_shift)
            begin
                if (ptr_reg > {1'b0, pick_reg} + 1'b1)
                begin
                    if ((ptr_reg - 1'b1 + extra_reg) < CntW'(MaxParts))
                    begin
                        start_reg[IdxW'(ptr_reg - 1'b1 + extra_reg)] <= start_reg[IdxW'(ptr_reg - 1'b1)];
                        size_reg[IdxW'(ptr_reg - 1'b1 + extra_reg)] <= size_reg[IdxW'(ptr_reg - 1'b1)];
                        kind_reg[IdxW'(ptr_reg - 1'b1 + extra_reg)] <= kind_reg[IdxW'(ptr_reg - 1'b1)];
                        owner_reg[IdxW'(ptr_reg - 1'b1 + extra_reg)] <= owner_reg[IdxW'(ptr_reg - 1'b1)];
                    end
                    ptr_reg <= ptr_reg - 1'b1;
                end
                else
                    count_reg <= count_reg + CntW'(extra_reg);
            end
            if (ctl.write && status_reg == ST_OK)
            begin
                case (req_reg.command)
                    CMD_CLEAR:
                    begin
                        for (int i = 0; i < MaxParts; i++)
                        begin
                            kind_reg[i] <= KIND_FREE;
                            start_reg[i] <= 16'd0;
                            size_reg[i] <= 16'd0;
                        end
                        size_reg[0] <= mem_size_reg;
                        count_reg <= (mem_size_reg != 16'd0) ? CntW'(1) : CntW'(0);
                    end
                    CMD_FIRST, CMD_BEST, CMD_WORST:
                    begin
                        kind_reg[pick_reg] <= KIND_OWNED;
                        owner_reg[pick_reg] <= req_reg.task_id;
                        size_reg[pick_reg] <= req_reg.req_size;
                        if (extra_reg != 2'd0)
                        begin
                            start_reg[mn] <= pstart_reg + req_reg.req_size;
                            size_reg[mn] <= aft_reg;
                            kind_reg[mn] <= KIND_FREE;
                            owner_reg[mn] <= '0;
                        end
                    end
                    CMD_FREE:
                    begin
                        kind_reg[pick_reg] <= KIND_FREE;
                        owner_reg[pick_reg] <= '0;
                    end
                    CMD_RESERVE:
                    begin
                        if (before_reg)
                        begin
                            size_reg[pick_reg] <= bef_reg;
                            start_reg[mn] <= req_reg.req_start;
                            size_reg[mn] <= req_reg.req_size;
                            kind_reg[mn] <= KIND_RESV;
                            owner_reg[mn] <= '0;
                            if (aft_reg != 16'd0)
                            begin
                                start_reg[IdxW'(pick_reg + 2'd2)] <= 16'(r_end);
                                size_reg[IdxW'(pick_reg + 2'd2)] <= aft_reg;
                                kind_reg[IdxW'(pick_reg + 2'd2)] <= KIND_FREE;
                                owner_reg[IdxW'(pick_reg + 2'd2)] <= '0;
                            end
                        end
                        else
                        begin
                            size_reg[pick_reg] <= req_reg.req_size;
                            kind_reg[pick_reg] <= KIND_RESV;
                            owner_reg[pick_reg] <= '0;
                            if (aft_reg != 16'd0)
                            begin
                                start_reg[mn] <= 16'(r_end);
                                size_reg[mn] <= aft_reg;
                                kind_reg[mn] <= KIND_FREE;
                                owner_reg[mn] <= '0;
                            end
                        end
                    end
                    default: count_reg <= count_reg;
                endcase
            end
            // merge: step 0 absorbs the next entry, step 1 folds into previous,
            // dropping a slot walks entries down one per cycle
            if (ctl.merge_step)
            begin
                if (dropping_reg)
                begin
                    if (ptr_reg + 1'b1 < count_reg)
                    begin
                        start_reg[pi] <= start_reg[IdxW'(ptr_reg + 1'b1)];
                        size_reg[pi] <= size_reg[IdxW'(ptr_reg + 1'b1)];
                        kind_reg[pi] <= kind_reg[IdxW'(ptr_reg + 1'b1)];
                        owner_reg[pi] <= owner_reg[IdxW'(ptr_reg + 1'b1)];
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        dropping_reg <= 1'b0;
                        mstep_reg <= mstep_reg + 1'b1;
                    end
                end
                else if (mstep_reg == 2'd0)
                begin
                    if ({1'b0, pick_reg} + 1'b1 < count_reg && kind_reg[mn] == KIND_FREE)
                    begin
                        size_reg[mi] <= size_reg[mi] + size_reg[mn];
                        ptr_reg <= CntW'(mn);
                        dropping_reg <= 1'b1;
                    end
                    else
                        mstep_reg <= 2'd1;
                end
                else if (mstep_reg == 2'd1)
                begin
                    if (pick_reg != '0 && kind_reg[IdxW'(pick_reg - 1'b1)] == KIND_FREE)
                    begin
                        size_reg[IdxW'(pick_reg - 1'b1)] <= size_reg[IdxW'(pick_reg - 1'b1)]
                                                          + size_reg[mi];
                        ptr_reg <= CntW'(pick_reg);
                        dropping_reg <= 1'b1;
                    end
                    else
                        mstep_reg <= 2'd2;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/variable_partition_allocator.sv */
// Variable-partition allocator: address-ordered table of up to 16 partitions.
// Channels: cmd (sink) carries one command word {command, task_id, req_size,
// req_start}; rsp (source) returns one word {status, block_start, block_size}
// per command. Config: cfg_we/cfg_data write memory_size (used by clear).
// Timing: one command at a time. Linear scan of the table, one entry a cycle,
// then a decide state, a shift state that moves later entries up one per cycle
// for a split, a write state, and for free up to two merges each walking the
// tail down one entry per cycle. The slowest command is a free that merges on
// both sides of a full table, since the scan, shift and merge loops each reach
// a single table entry per step. A new command is accepted only after the
// response to the last one has been taken.
// The response is held in the datapath until taken; while the receiver
// stalls, no new command is accepted.
// Reset: table holds one free hole of 3000 units at 0, memory_size = 3000.
`default_nettype none
module variable_partition_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    vpa_req_if.sink          cmd,
    vpa_rsp_if.source        rsp
);
    import vpa_pkg::*;

    ctl_t ctl;
    sts_t sts;

    vpa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(cmd.valid), .in_ready(cmd.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .sts(sts), .ctl(ctl)
    );

    vpa_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .req(cmd.data), .ctl(ctl), .sts(sts), .rsp(rsp.data)
    );
endmodule
`default_nettype wire

/* hdl/vpa_checker.sv */
`default_nettype none
module vpa_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [2:0] status,
    input wire logic [15:0] block_size
);
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("accept while result pending");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != 3'd0) |-> block_size == 16'd0)
        else $error("nonzero size on failure");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 3'd4) else $error("bad status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind variable_partition_allocator vpa_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(cmd.valid), .in_ready(cmd.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .status(rsp.data.status), .block_size(rsp.data.block_size)
);
`default_nettype wire

/* tb/vpa_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module vpa_scoreboard
    import vpa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    vpa_req_if               cmd,
    vpa_rsp_if               rsp,
    output int               errors,
    output int               pending
);
    logic [15:0] mem_size;
    logic [15:0] p_start [MaxParts];
    logic [15:0] p_size [MaxParts];
    kind_t       p_kind [MaxParts];
    logic [15:0] p_owner [MaxParts];
    int          p_count;
    rsp_t        expected_words [$];

    function automatic void clear_table();
        for (int i = 0; i < MaxParts; i++)
        begin
            p_start[i] = '0;
            p_size[i] = '0;
            p_kind[i] = KIND_FREE;
            p_owner[i] = '0;
        end
        p_size[0] = mem_size;
        p_count = (mem_size != 0) ? 1 : 0;
    endfunction

    function automatic void set_entry(int i, int st, int sz, kind_t kd, logic [15:0] own);
        p_start[i] = st[15:0];
        p_size[i] = sz[15:0];
        p_kind[i] = kd;
        p_owner[i] = own;
    endfunction

    function automatic void open_slots(int idx, int n);
        for (int i = p_count; i > idx; i--)
        begin
            if (i - 1 + n < MaxParts)
                set_entry(i - 1 + n, p_start[i - 1], p_size[i - 1], p_kind[i - 1],
                    p_owner[i - 1]);
        end
        p_count += n;
    endfunction

    function automatic void drop_slot(int idx);
        for (int i = idx; i + 1 < p_count; i++)
            set_entry(i, p_start[i + 1], p_size[i + 1], p_kind[i + 1], p_owner[i + 1]);
        if (p_count > 0)
            p_count--;
    endfunction

    // next table state and response for one command word
    function automatic rsp_t allocate_step(req_t r);
        rsp_t o;
        int   pick;
        bit   found;
        int   rend, hs, he, pre, post, extra, pos;
        o = '0;
        o.status = ST_BAD;
        found = 0;
        pick = 0;
        case (r.command)
            CMD_CLEAR:
            begin
                clear_table();
                o.status = ST_OK;
                o.block_size = mem_size;
            end
            CMD_FIRST, CMD_BEST, CMD_WORST:
                if (r.req_size != 0)
                begin
                    for (int i = 0; i < p_count; i++)
                    begin
                        if (p_kind[i] != KIND_FREE || p_size[i] < r.req_size)
                            continue;
                        if (!found)
                        begin
                            found = 1;
                            pick = i;
                            if (r.command == CMD_FIRST)
                                break;
                        end
                        else if ((r.command == CMD_BEST && p_size[i] < p_size[pick]) ||
                                 (r.command == CMD_WORST && p_size[i] > p_size[pick]))
                            pick = i;
                    end
                    if (!found)
                        o.status = ST_NOFIT;
                    else if (p_size[pick] == r.req_size)
                    begin
                        p_kind[pick] = KIND_OWNED;
                        p_owner[pick] = r.task_id;
                        o.status = ST_OK;
                        o.block_start = p_start[pick];
                        o.block_size = r.req_size;
                    end
                    else if (p_count + 1 > MaxParts)
                        o.status = ST_FULL;
                    else
                    begin
                        hs = p_start[pick];
                        post = int'(p_size[pick]) - int'(r.req_size);
                        open_slots(pick + 1, 1);
                        set_entry(pick, hs, r.req_size, KIND_OWNED, r.task_id);
                        set_entry(pick + 1, hs + r.req_size, post, KIND_FREE, '0);
                        o.status = ST_OK;
                        o.block_start = hs[15:0];
                        o.block_size = r.req_size;
                    end
                end
            CMD_FREE:
            begin
                for (int i = 0; i < p_count; i++)
                    if (p_kind[i] == KIND_OWNED && p_owner[i] == r.task_id)
                    begin
                        found = 1;
                        pick = i;
                        break;
                    end
                if (!found)
                    o.status = ST_NOID;
                else
                begin
                    o.status = ST_OK;
                    o.block_start = p_start[pick];
                    o.block_size = p_size[pick];
                    p_kind[pick] = KIND_FREE;
                    p_owner[pick] = '0;
                    if (pick + 1 < p_count && p_kind[pick + 1] == KIND_FREE)
                    begin
                        p_size[pick] = p_size[pick] + p_size[pick + 1];
                        drop_slot(pick + 1);
                    end
                    if (pick > 0 && p_kind[pick - 1] == KIND_FREE)
                    begin
                        p_size[pick - 1] = p_size[pick - 1] + p_size[pick];
                        drop_slot(pick);
                    end
                end
            end
            CMD_RESERVE:
                if (r.req_size != 0)
                begin
                    rend = int'(r.req_start) + int'(r.req_size);
                    for (int i = 0; i < p_count; i++)
                        if (p_kind[i] == KIND_FREE && p_start[i] <= r.req_start &&
                            int'(p_start[i]) + int'(p_size[i]) >= rend)
                        begin
                            found = 1;
                            pick = i;
                            break;
                        end
                    if (!found || rend > 32'h10000)
                        o.status = ST_NOFIT;
                    else
                    begin
                        hs = p_start[pick];
                        he = hs + int'(p_size[pick]);
                        pre = int'(r.req_start) - hs;
                        post = he - rend;
                        extra = (pre != 0) + (post != 0);
                        if (p_count + extra > MaxParts)
                            o.status = ST_FULL;
                        else
                        begin
                            pos = pick;
                            if (extra != 0)
                                open_slots(pick + 1, extra);
                            if (pre != 0)
                            begin
                                set_entry(pos, hs, pre, KIND_FREE, '0);
                                pos++;
                            end
                            set_entry(pos, r.req_start, r.req_size, KIND_RESV, '0);
                            if (post != 0)
                                set_entry(pos + 1, rend, post, KIND_FREE, '0);
                            o.status = ST_OK;
                            o.block_start = r.req_start;
                            o.block_size = r.req_size;
                        end
                    end
                end
            default: ;
        endcase
        if (o.status != ST_OK)
        begin
            o.block_start = '0;
            o.block_size = '0;
        end
        return o;
    endfunction

    task automatic report_mismatch(string field, int want, int got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
        errors++;
    endtask

    initial errors = 0;
    assign pending = expected_words.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            mem_size = MemReset;
            clear_table();
            expected_words.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: response word with nothing outstanding", $realtime);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp.data.status !== want.status)
                        report_mismatch("status", want.status, rsp.data.status);
                    if (rsp.data.block_start !== want.block_start)
                        report_mismatch("block_start", want.block_start,
                            rsp.data.block_start);
                    if (rsp.data.block_size !== want.block_size)
                        report_mismatch("block_size", want.block_size,
                            rsp.data.block_size);
                end
            end
            if (cmd.valid && cmd.ready)
                expected_words.push_back(allocate_step(cmd.data));
            if (cfg_we)
                mem_size = cfg_data;
        end
    end
endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import vpa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;

    // idle_mode: 0 none, 1 sender gaps, 2 receiver stalls, 3 both light
    int          idle_mode;
    int          hold_cycles;     // requested long receiver hold-off
    logic [15:0] cur_mem;         // memory_size as last written, for shaping sizes

    vpa_req_if cmd_ch ();
    vpa_rsp_if rsp_ch ();

    variable_partition_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd_ch.sink),
        .rsp      (rsp_ch.source)
    );

    vpa_scoreboard u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd_ch),
        .rsp      (rsp_ch),
        .errors   (errors),
        .pending  (pending)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // generous watchdog
    initial
    begin
        #20ms;
        $display("tb: done, errors");
        $finish;
    end

    // Receiver side: long hold-off when asked, else stall per idle mode.
    initial
    begin
        int held;
        held = 0;
        rsp_ch.ready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0 && held < hold_cycles)
            begin
                held++;
                rsp_ch.ready <= 0;
            end
            else
            begin
                if (held != 0)
                begin
                    hold_cycles = 0;
                    held = 0;
                end
                case (idle_mode)
                    2: rsp_ch.ready <= ($urandom_range(0, 99) >= 82);
                    3: rsp_ch.ready <= ($urandom_range(0, 99) >= 11);
                    default: rsp_ch.ready <= 1;
                endcase
            end
        end
    end

    // Offer one command word and hold it until accepted. Gaps come first,
    // so valid gets only one update per edge.
    task automatic send_word(logic [2:0] c, logic [15:0] id, logic [15:0] sz,
                             logic [15:0] st);
        int gap_pct;
        req_t r;
        gap_pct = (idle_mode == 1) ? 82 : (idle_mode == 3) ? 11 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            cmd_ch.valid <= 0;
            @(posedge clk);
        end
        r.command = c;
        r.task_id = id;
        r.req_size = sz;
        r.req_start = st;
        cmd_ch.valid <= 1;
        cmd_ch.data <= r;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // Quiesce, then write memory_size.
    task automatic write_mem_size(logic [15:0] v);
        cmd_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= v;
        cur_mem = v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // Mostly well-formed traffic: small ids so frees hit, sizes scaled to memory.
    task automatic random_word();
        int   pick;
        logic [2:0]  c;
        logic [15:0] id, sz, st;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c = 3'($urandom_range(CMD_FIRST, CMD_WORST));
        else if (pick < 77)
            c = CMD_FREE;
        else if (pick < 92)
            c = CMD_RESERVE;
        else if (pick < 96)
            c = CMD_CLEAR;
        else
            c = 3'($urandom_range(CMD_CLEAR, CMD_BAD7));
        id = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 15)) : 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 65)
            sz = 16'($urandom_range(1, cur_mem / 8 + 1));
        else if (pick < 80)
            sz = 16'($urandom_range(1, 4));
        else if (pick < 92)
            sz = 16'($urandom);
        else if (pick < 96)
            sz = 16'hffff;
        else
            sz = '0;
        if ($urandom_range(0, 99) < 80)
            st = 16'($urandom_range(0, cur_mem));
        else
            st = 16'($urandom);
        send_word(c, id, sz, st);
    endtask

    initial
    begin
        logic [15:0] sizes [4];
        idle_mode = 0;
        hold_cycles = 0;
        cur_mem = MemReset;
        rst_n = 0;
        cfg_we = 0;
        cfg_data = '0;
        cmd_ch.valid = 0;
        cmd_ch.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: fit kinds, exact fit, split, merges, reserve edges,
        // zero size, unknown ids, unused codes
        send_word(CMD_FIRST, 16'd1, 16'd100, '0);
        send_word(CMD_BEST, 16'd2, 16'd200, '0);
        send_word(CMD_WORST, 16'd3, 16'd300, '0);
        send_word(CMD_FREE, 16'd2, '0, '0);
        send_word(CMD_BEST, 16'd4, 16'd200, '0);       // exact fit in old hole
        send_word(CMD_FREE, 16'd1, '0, '0);
        send_word(CMD_FREE, 16'd4, '0, '0);            // merge with free before
        send_word(CMD_FREE, 16'd3, '0, '0);            // merge both sides
        send_word(CMD_FREE, 16'hffff, '0, '0);         // id not found
        send_word(CMD_FIRST, 16'd5, '0, '0);           // zero size
        send_word(CMD_RESERVE, '0, '0, 16'd10);        // zero size
        send_word(CMD_FIRST, 16'd5, 16'hffff, '0);     // no fit
        send_word(CMD_RESERVE, '0, 16'd50, 16'd1000);  // splits into three
        send_word(CMD_RESERVE, '0, 16'd10, 16'd1040);  // inside reserved: no fit
        send_word(CMD_RESERVE, '0, 16'hffff, 16'hfffe); // past top of memory
        send_word(CMD_RESERVE, '0, 16'd1950, 16'd1050); // runs to hole end
        send_word(CMD_BAD6, 16'hffff, 16'hffff, 16'hffff);
        send_word(CMD_BAD7, '0, 16'd1, '0);
        send_word(CMD_CLEAR, '0, '0, '0);
        // fill the table with unit allocations until it reports full
        for (int i = 0; i < 17; i++)
            send_word(CMD_FIRST, 16'(i + 100), 16'd1, '0);
        send_word(CMD_RESERVE, '0, 16'd1, 16'd2000);   // needs two slots: full

        sizes[0] = MemReset;
        sizes[1] = 16'hffff;
        sizes[2] = 16'd1;
        sizes[3] = 16'($urandom_range(16, 4000));
        for (int ph = 0; ph < 4; ph++)
        begin
            write_mem_size(sizes[ph]);
            idle_mode = (ph == 0) ? 0 : ph;
            send_word(CMD_CLEAR, '0, '0, '0);
            if (ph == 0)
                hold_cycles = 400;  // block fills and stalls its input
            for (int n = 0; n < 320; n++)
                random_word();
        end
        // best fit over a hole as large as memory
        write_mem_size(16'hffff);
        send_word(CMD_CLEAR, '0, '0, '0);
        send_word(CMD_BEST, 16'd7, 16'hffff, '0);
        send_word(CMD_FREE, 16'd7, '0, '0);
        cmd_ch.valid <= 0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
